// File: rtl/double_ended_queue_unit_assert.svh
// assertion macros for the double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deq assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deq assertion failed");
`else
`define DEQ_ASSERT_IMP(label, ante, cons)
`define DEQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/deq_pkg.sv
// package: widths, command codes and shared types of the double-ended queue
`timescale 1ns / 1ps
package deq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_ALL  = 3'd5;

    // result status from the controller to the output stage
    typedef struct packed {
        logic valid;
        logic ok;
        logic readout;
        logic last;
    } deq_resp_t;

endpackage

// File: rtl/deq_ifs.sv
// valid/ready channel interfaces: command items in, result items out
`timescale 1ns / 1ps
interface deq_cmd_if import deq_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_res_if import deq_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] item_value;
    logic                      item_valid;
    logic                      last;

    modport source (output valid, output ok, output count, output item_value,
                    output item_valid, output last, input ready);
    modport sink   (input valid, input ok, input count, input item_value,
                    input item_valid, input last, output ready);
endinterface

// File: rtl/deq_mem.sv
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
module deq_mem import deq_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/deq_ctrl.sv
// queue controller: front index, count, command decode and read-out sequencing
`timescale 1ns / 1ps
module deq_ctrl import deq_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    deq_cmd_if.sink               cmd,
    input  logic                  out_ready,
    output deq_resp_t             resp,
    output logic [COUNT_W-1:0]    count,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data,
    output logic [IDX_W-1:0]      rd_addr
);

    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(CAPACITY);
    localparam logic [COUNT_W:0]   CAP_SUM  = (COUNT_W + 1)'(CAPACITY);
    localparam logic [COUNT_W-1:0] ONE_CNT  = COUNT_W'(1);

    localparam logic ST_CMD  = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic               state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] rd_left_reg, rd_left_next;

    logic               accept;
    logic               full;
    logic               empty;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic [IDX_W-1:0]   rd_ptr_inc;
    logic [COUNT_W:0]   back_sum;
    logic [IDX_W-1:0]   back_idx;

    assign cmd.ready = (state_reg == ST_CMD) && (!res_valid_reg || out_ready);
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);

    // ring index arithmetic
    assign front_dec  = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc  = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IDX_W'(1);
    assign back_sum   = (COUNT_W + 1)'(front_reg) + {1'b0, count_reg};
    assign back_idx   = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM)
                                              : IDX_W'(back_sum);

    assign wr_data = DATA_WIDTH'($unsigned(cmd.value));

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && !out_ready;
        res_ok_next    = res_ok_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_left_next   = rd_left_reg;
        wr_en          = 1'b0;
        wr_addr        = back_idx;
        rd_addr        = front_reg;

        if (state_reg == ST_CMD)
        begin
            if (accept)
            begin
                res_valid_next = 1'b1;
                res_ok_next    = 1'b1;
                unique case (cmd.command)
                    CMD_ADD_FRONT:
                    begin
                        if (full)
                        begin
                            res_ok_next = 1'b0;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = front_dec;
                            front_next = front_dec;
                            count_next = count_reg + ONE_CNT;
                        end
                    end
                    CMD_ADD_BACK:
                    begin
                        if (full)
                        begin
                            res_ok_next = 1'b0;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + ONE_CNT;
                        end
                    end
                    CMD_REM_FRONT:
                    begin
                        if (empty)
                        begin
                            res_ok_next = 1'b0;
                        end
                        else
                        begin
                            front_next = front_inc;
                            count_next = count_reg - ONE_CNT;
                        end
                    end
                    CMD_REM_BACK:
                    begin
                        if (empty)
                        begin
                            res_ok_next = 1'b0;
                        end
                        else
                        begin
                            count_next = count_reg - ONE_CNT;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    CMD_READ_ALL:
                    begin
                        // empty read-out is a single result from the result register
                        if (!empty)
                        begin
                            res_valid_next = 1'b0;
                            state_next     = ST_READ;
                            rd_ptr_next    = front_reg;
                            rd_left_next   = count_reg;
                        end
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            // address the entry that is current in the next cycle
            if (out_ready)
            begin
                rd_addr      = rd_ptr_inc;
                rd_ptr_next  = rd_ptr_inc;
                rd_left_next = rd_left_reg - ONE_CNT;
                if (rd_left_reg == ONE_CNT)
                begin
                    state_next = ST_CMD;
                end
            end
            else
            begin
                rd_addr = rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CMD;
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg  <= res_ok_next;
        rd_ptr_reg  <= rd_ptr_next;
        rd_left_reg <= rd_left_next;
    end

    assign resp.valid   = res_valid_reg || (state_reg == ST_READ);
    assign resp.ok      = (state_reg == ST_READ) || res_ok_reg;
    assign resp.readout = (state_reg == ST_READ);
    assign resp.last    = (state_reg == ST_CMD) || (rd_left_reg == ONE_CNT);
    assign count        = count_reg;

endmodule

// File: rtl/double_ended_queue_unit.sv
// top level of the double-ended queue unit
`timescale 1ns / 1ps
`include "double_ended_queue_unit_assert.svh"
// Double-ended queue of DATA_WIDTH-bit entries kept in a circular buffer of
// CAPACITY entries in one synchronous memory (one write port, one read port
// with a registered output). Each command item gives one result item with ok
// and the entry count after the command; read-all gives one result per stored
// entry from front to back, the last one marked, or a single result with no
// entry when the queue is empty. Adds are refused with ok=0 when the queue is
// full, removes with ok=0 when it is empty, unknown codes give ok=0. Add,
// remove and clear items are accepted back to back, so one item per cycle is
// sustained as long as results are taken. Read-all of N entries holds the
// command side from acceptance until all N entries are out: the single
// memory read port delivers one entry per cycle, and a stall on the result
// side holds the read-out. Stored values enter as the low DATA_WIDTH bits
// of value and leave sign-extended (or truncated) to 32 bits. The memory
// needs no clearing pass after reset; entries are only read once written.
module double_ended_queue_unit import deq_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    deq_cmd_if.sink  cmd,
    deq_res_if.source res
);

    localparam int IDX_W = $clog2(CAPACITY);

    deq_resp_t             resp;
    logic [COUNT_W-1:0]    count;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    // pointers, count and command decode
    deq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_ready (res.ready),
        .resp      (resp),
        .count     (count),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr)
    );

    // entry store
    deq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result side: read-out items come straight from the memory output register
    assign res.valid      = resp.valid;
    assign res.ok         = resp.ok;
    assign res.count      = count;
    assign res.item_valid = resp.readout;
    assign res.last       = resp.last;
    assign res.item_value = resp.readout ? VALUE_W'($signed(rd_data)) : '0;

    // no command is taken while a read-out is in progress
    `DEQ_ASSERT_IMP(a_no_cmd_in_readout, resp.readout, !cmd.ready)
    // the count never exceeds the capacity
    `DEQ_ASSERT_IMP(a_count_bound, 1'b1, count <= COUNT_W'(CAPACITY))
    // a read-out entry only appears on a successful result
    `DEQ_ASSERT_IMP(a_item_ok, res.valid && res.item_valid, res.ok)

endmodule
